>>> hw/rtl/assert_macros.svh
// assertion macros for the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define BSC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define BSC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/bsc_pkg.sv
// package with widths, register map, constants and helpers of the compensation block
`timescale 1ns / 1ps

package bsc_pkg;

    // field widths
    localparam int RAW_W   = 24;
    localparam int VALUE_W = 32;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // register map, index is the word address
    typedef enum logic [2:0] {
        REG_OVERSAMPLING = 3'd0,
        REG_AC1          = 3'd1,
        REG_AC2          = 3'd2,
        REG_AC3          = 3'd3,
        REG_AC4          = 3'd4,
        REG_AC5_AC6      = 3'd5,
        REG_B1_B2        = 3'd6,
        REG_MC_MD        = 3'd7
    } bsc_reg_t;

    // item kinds
    localparam logic CMD_TEMP  = 1'b0;
    localparam logic CMD_PRESS = 1'b1;

    // register reset values
    localparam logic [1:0]  OSS_RESET   = 2'd3;
    localparam logic [15:0] AC1_RESET   = 16'd408;
    localparam logic [15:0] AC2_RESET   = 16'hFFB8;
    localparam logic [15:0] AC3_RESET   = 16'hC7D1;
    localparam logic [15:0] AC4_RESET   = 16'd32741;
    localparam logic [31:0] AC56_RESET  = 32'd2146785905;
    localparam logic [31:0] B1B2_RESET  = 32'd405667844;
    localparam logic [31:0] MCMD_RESET  = 32'd3724086068;

    // compensation constants
    localparam logic [31:0] B6_OFFSET   = 32'd4000;
    localparam logic [31:0] X3_BIAS     = 32'd32768;
    localparam logic [31:0] B7_SCALE    = 32'd50000;
    localparam logic [31:0] P_COEF_SQ   = 32'd3038;
    localparam logic [31:0] P_COEF_LIN  = 32'hFFFF_E343;
    localparam logic [31:0] P_COEF_OFS  = 32'd3791;
    localparam logic [31:0] T_ROUND     = 32'd8;
    localparam logic [31:0] X3_ROUND    = 32'd2;

    // arithmetic shift right of a 32-bit word
    function automatic logic [31:0] sra32(input logic [31:0] v, input logic [4:0] sh);
        sra32 = 32'($signed(v) >>> sh);
    endfunction

    // sign extension of a 16-bit coefficient
    function automatic logic [31:0] sext16(input logic [15:0] v);
        sext16 = {{16{v[15]}}, v};
    endfunction

endpackage

>>> hw/rtl/bsc_if.sv
// stream interfaces for raw readings and compensated results
`timescale 1ns / 1ps

// raw reading channel
interface bsc_sample_if
    import bsc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [RAW_W-1:0]   raw_reading;

    modport source (output valid, output cmd, output raw_reading, input ready);
    modport sink   (input valid, input cmd, input raw_reading, output ready);
endinterface

// compensated result channel
interface bsc_result_if
    import bsc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [VALUE_W-1:0] value;
    logic               div_error;

    modport source (output valid, output kind, output value, output div_error, input ready);
    modport sink   (input valid, input kind, input value, input div_error, output ready);
endinterface

>>> hw/rtl/baro_sensor_compensation.sv
// top level: barometric temperature and pressure compensation with shared multiplier
// the block takes a reading only when idle and takes no new one until the last has gone to
// the output register; a zero divisor skips the radix-2 divider and gives an error result;
//   the sequenced 32x32 multiplier gives one product per cycle, registered
// a finished result waits in the output register while the next item is taken
// reset: asynchronous active low, restores the calibration registers and clears stored b5
`timescale 1ns / 1ps
`include "assert_macros.svh"

module baro_sensor_compensation
    import bsc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    bsc_sample_if.sink          sample,
    bsc_result_if.source        result
);

    // sequencer states, one-hot
    typedef enum logic [21:0] {
        S_IDLE   = 22'h000001,
        S_T_MUL  = 22'h000002,
        S_T_X1   = 22'h000004,
        S_T_DSET = 22'h000008,
        S_T_QS   = 22'h000010,
        S_T_B5   = 22'h000020,
        S_P_M0   = 22'h000040,
        S_P_SQ   = 22'h000080,
        S_P_X2   = 22'h000100,
        S_P_B3   = 22'h000200,
        S_P_X13  = 22'h000400,
        S_P_X3   = 22'h000800,
        S_P_M5   = 22'h001000,
        S_P_B4   = 22'h002000,
        S_P_B7   = 22'h004000,
        S_DIV    = 22'h008000,
        S_P_P    = 22'h010000,
        S_P_M7   = 22'h020000,
        S_P_M8   = 22'h040000,
        S_P_X1F  = 22'h080000,
        S_P_FIN  = 22'h100000,
        S_OUT    = 22'h200000
    } bsc_state_t;

    // configuration registers
    logic [1:0]  oss_reg,  oss_next;
    logic [15:0] ac1_reg,  ac1_next;
    logic [15:0] ac2_reg,  ac2_next;
    logic [15:0] ac3_reg,  ac3_next;
    logic [15:0] ac4_reg,  ac4_next;
    logic [31:0] ac56_reg, ac56_next;
    logic [31:0] b1b2_reg, b1b2_next;
    logic [31:0] mcmd_reg, mcmd_next;

    // control state
    bsc_state_t  state_reg, state_next;
    logic [4:0]  div_cnt_reg, div_cnt_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] b5_reg, b5_next;

    // working registers
    logic        cmd_reg, cmd_next;
    logic [31:0] opa_reg, opa_next;
    logic [31:0] b6_reg, b6_next;
    logic [31:0] sq_reg, sq_next;
    logic [31:0] x1_reg, x1_next;
    logic [31:0] x2_reg, x2_next;
    logic [31:0] b3_reg, b3_next;
    logic [31:0] b4_reg, b4_next;
    logic [31:0] b7_reg, b7_next;
    logic [31:0] p_reg, p_next;
    logic [31:0] prod_reg, prod_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [31:0] val_reg, val_next;
    logic        err_reg, err_next;
    logic        out_kind_reg, out_kind_next;
    logic [31:0] out_value_reg, out_value_next;
    logic        out_err_reg, out_err_next;

    // combinational helpers
    logic        cfg_write;
    logic        accept;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [32:0] div_shift;
    logic [32:0] div_trial;
    logic [31:0] ac1_s, ac2_s, ac3_s, b1_s, b2_s, mc_s, md_s;
    logic [31:0] mc_shl;
    logic [31:0] x3_sum;
    logic [31:0] b3_pre;
    logic [31:0] b5_sum;
    logic [31:0] t_p;

    // apb side
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_comb
    begin
        unique case (bsc_reg_t'(paddr[ADDR_W-1:2]))
            REG_OVERSAMPLING: prdata = {30'd0, oss_reg};
            REG_AC1:          prdata = {16'd0, ac1_reg};
            REG_AC2:          prdata = {16'd0, ac2_reg};
            REG_AC3:          prdata = {16'd0, ac3_reg};
            REG_AC4:          prdata = {16'd0, ac4_reg};
            REG_AC5_AC6:      prdata = ac56_reg;
            REG_B1_B2:        prdata = b1b2_reg;
            REG_MC_MD:        prdata = mcmd_reg;
            default:          prdata = '0;
        endcase
    end

    // register writes
    always_comb
    begin
        oss_next  = oss_reg;
        ac1_next  = ac1_reg;
        ac2_next  = ac2_reg;
        ac3_next  = ac3_reg;
        ac4_next  = ac4_reg;
        ac56_next = ac56_reg;
        b1b2_next = b1b2_reg;
        mcmd_next = mcmd_reg;
        if (cfg_write)
        begin
            unique case (bsc_reg_t'(paddr[ADDR_W-1:2]))
                REG_OVERSAMPLING: oss_next  = pwdata[1:0];
                REG_AC1:          ac1_next  = pwdata[15:0];
                REG_AC2:          ac2_next  = pwdata[15:0];
                REG_AC3:          ac3_next  = pwdata[15:0];
                REG_AC4:          ac4_next  = pwdata[15:0];
                REG_AC5_AC6:      ac56_next = pwdata;
                REG_B1_B2:        b1b2_next = pwdata;
                REG_MC_MD:        mcmd_next = pwdata;
                default:          oss_next  = oss_reg;
            endcase
        end
    end

    // signed coefficients
    assign ac1_s  = sext16(ac1_reg);
    assign ac2_s  = sext16(ac2_reg);
    assign ac3_s  = sext16(ac3_reg);
    assign b1_s   = sext16(b1b2_reg[31:16]);
    assign b2_s   = sext16(b1b2_reg[15:0]);
    assign mc_s   = sext16(mcmd_reg[31:16]);
    assign md_s   = sext16(mcmd_reg[15:0]);
    assign mc_shl = mc_s << 11;

    // handshake
    assign sample.ready     = (state_reg == S_IDLE);
    assign accept           = sample.valid & sample.ready;
    assign result.valid     = out_valid_reg;
    assign result.kind      = out_kind_reg;
    assign result.value     = out_value_reg;
    assign result.div_error = out_err_reg;

    // divider step: restoring, one quotient bit a cycle
    assign div_shift = {rem_reg, quo_reg[31]};
    assign div_trial = div_shift - {1'b0, dvs_reg};

    // small adders used in writeback steps
    assign x3_sum = x2_reg + sra32(prod_reg, 5'd11);
    assign b3_pre = ((ac1_s << 2) + x3_sum) << oss_reg;
    assign b5_sum = x1_reg + x2_reg;
    assign t_p    = sra32(p_reg, 5'd8);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_T_MUL:
            begin
                mul_a = opa_reg;
                mul_b = {16'd0, ac56_reg[31:16]};
            end
            S_P_M0:
            begin
                mul_a = b6_reg;
                mul_b = b6_reg;
            end
            S_P_SQ:
            begin
                mul_a = ac2_s;
                mul_b = b6_reg;
            end
            S_P_X2:
            begin
                mul_a = b2_s;
                mul_b = sq_reg;
            end
            S_P_B3:
            begin
                mul_a = ac3_s;
                mul_b = b6_reg;
            end
            S_P_X13:
            begin
                mul_a = b1_s;
                mul_b = sq_reg;
            end
            S_P_M5:
            begin
                mul_a = {16'd0, ac4_reg};
                mul_b = x2_reg;
            end
            S_P_B4:
            begin
                mul_a = b3_reg;
                mul_b = B7_SCALE >> oss_reg;
            end
            S_P_M7:
            begin
                mul_a = t_p;
                mul_b = t_p;
            end
            S_P_M8:
            begin
                mul_a = prod_reg;
                mul_b = P_COEF_SQ;
            end
            S_P_X1F:
            begin
                mul_a = p_reg;
                mul_b = P_COEF_LIN;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = 32'(mul_a * mul_b);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg;
        b5_next        = b5_reg;
        cmd_next       = cmd_reg;
        opa_next       = opa_reg;
        b6_next        = b6_reg;
        sq_next        = sq_reg;
        x1_next        = x1_reg;
        x2_next        = x2_reg;
        b3_next        = b3_reg;
        b4_next        = b4_reg;
        b7_next        = b7_reg;
        p_next         = p_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dvs_next       = dvs_reg;
        neg_next       = neg_reg;
        val_next       = val_reg;
        err_next       = err_reg;
        out_kind_next  = out_kind_reg;
        out_value_next = out_value_reg;
        out_err_next   = out_err_reg;

        // result register drains independently
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = sample.cmd;
                    err_next = 1'b0;
                    val_next = '0;
                    b6_next  = b5_reg - B6_OFFSET;
                    if (sample.cmd == CMD_TEMP)
                    begin
                        opa_next   = {16'd0, sample.raw_reading[15:0]}
                                   - {16'd0, ac56_reg[15:0]};
                        state_next = S_T_MUL;
                    end
                    else
                    begin
                        opa_next   = {8'd0, sample.raw_reading >> (4'd8 - {2'b00, oss_reg})};
                        state_next = S_P_M0;
                    end
                end
            end

            // temperature: x1 and divisor
            S_T_MUL:
            begin
                state_next = S_T_X1;
            end
            S_T_X1:
            begin
                x1_next    = sra32(prod_reg, 5'd15);
                x2_next    = sra32(prod_reg, 5'd15) + md_s;
                state_next = S_T_DSET;
            end
            S_T_DSET:
            begin
                if (x2_reg == '0)
                begin
                    err_next   = 1'b1;
                    val_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    rem_next     = '0;
                    quo_next     = mc_shl[31] ? (32'd0 - mc_shl) : mc_shl;
                    dvs_next     = x2_reg[31] ? (32'd0 - x2_reg) : x2_reg;
                    neg_next     = mc_shl[31] ^ x2_reg[31];
                    div_cnt_next = '1;
                    state_next   = S_DIV;
                end
            end
            S_T_QS:
            begin
                x2_next    = neg_reg ? (32'd0 - quo_reg) : quo_reg;
                state_next = S_T_B5;
            end
            S_T_B5:
            begin
                b5_next    = b5_sum;
                val_next   = sra32(b5_sum + T_ROUND, 5'd4);
                state_next = S_OUT;
            end

            // pressure: b3, b4, b7 through the shared multiplier
            S_P_M0:
            begin
                state_next = S_P_SQ;
            end
            S_P_SQ:
            begin
                sq_next    = sra32(prod_reg, 5'd12);
                state_next = S_P_X2;
            end
            S_P_X2:
            begin
                x2_next    = sra32(prod_reg, 5'd11);
                state_next = S_P_B3;
            end
            S_P_B3:
            begin
                b3_next    = sra32(b3_pre + X3_ROUND, 5'd2);
                state_next = S_P_X13;
            end
            S_P_X13:
            begin
                x1_next    = sra32(prod_reg, 5'd13);
                b3_next    = opa_reg - b3_reg;
                state_next = S_P_X3;
            end
            S_P_X3:
            begin
                x2_next    = sra32(x1_reg + sra32(prod_reg, 5'd16) + X3_ROUND, 5'd2)
                           + X3_BIAS;
                state_next = S_P_M5;
            end
            S_P_M5:
            begin
                state_next = S_P_B4;
            end
            S_P_B4:
            begin
                b4_next    = prod_reg >> 15;
                state_next = S_P_B7;
            end
            S_P_B7:
            begin
                b7_next = prod_reg;
                if (b4_reg == '0)
                begin
                    err_next   = 1'b1;
                    val_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    rem_next     = '0;
                    quo_next     = prod_reg[31] ? prod_reg : (prod_reg << 1);
                    dvs_next     = b4_reg;
                    div_cnt_next = '1;
                    state_next   = S_DIV;
                end
            end

            // shared divider iterations
            S_DIV:
            begin
                if (div_trial[32])
                begin
                    rem_next = div_shift[31:0];
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                else
                begin
                    rem_next = div_trial[31:0];
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                div_cnt_next = div_cnt_reg - 5'd1;
                if (div_cnt_reg == '0)
                begin
                    state_next = (cmd_reg == CMD_PRESS) ? S_P_P : S_T_QS;
                end
            end

            // pressure: final polynomial
            S_P_P:
            begin
                p_next     = b7_reg[31] ? (quo_reg << 1) : quo_reg;
                state_next = S_P_M7;
            end
            S_P_M7:
            begin
                state_next = S_P_M8;
            end
            S_P_M8:
            begin
                state_next = S_P_X1F;
            end
            S_P_X1F:
            begin
                x1_next    = sra32(prod_reg, 5'd16);
                state_next = S_P_FIN;
            end
            S_P_FIN:
            begin
                val_next   = p_reg + sra32(x1_reg + sra32(prod_reg, 5'd16) + P_COEF_OFS,
                                           5'd4);
                state_next = S_OUT;
            end

            // hand the item to the result register once it is free
            S_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = cmd_reg;
                    out_value_next = val_reg;
                    out_err_next   = err_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            b5_reg        <= '0;
            oss_reg       <= OSS_RESET;
            ac1_reg       <= AC1_RESET;
            ac2_reg       <= AC2_RESET;
            ac3_reg       <= AC3_RESET;
            ac4_reg       <= AC4_RESET;
            ac56_reg      <= AC56_RESET;
            b1b2_reg      <= B1B2_RESET;
            mcmd_reg      <= MCMD_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
            b5_reg        <= b5_next;
            oss_reg       <= oss_next;
            ac1_reg       <= ac1_next;
            ac2_reg       <= ac2_next;
            ac3_reg       <= ac3_next;
            ac4_reg       <= ac4_next;
            ac56_reg      <= ac56_next;
            b1b2_reg      <= b1b2_next;
            mcmd_reg      <= mcmd_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        opa_reg       <= opa_next;
        b6_reg        <= b6_next;
        sq_reg        <= sq_next;
        x1_reg        <= x1_next;
        x2_reg        <= x2_next;
        b3_reg        <= b3_next;
        b4_reg        <= b4_next;
        b7_reg        <= b7_next;
        p_reg         <= p_next;
        prod_reg      <= prod_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        dvs_reg       <= dvs_next;
        neg_reg       <= neg_next;
        val_reg       <= val_next;
        err_reg       <= err_next;
        out_kind_reg  <= out_kind_next;
        out_value_reg <= out_value_next;
        out_err_reg   <= out_err_next;
    end

    // checks
    `BSC_ASSERT(a_div_nonzero, clk, rst_n,
        (state_reg == S_DIV) |-> (dvs_reg != '0), "divider runs with zero divisor")
    `BSC_ASSERT(a_err_zero, clk, rst_n,
        (out_valid_reg && out_err_reg) |-> (out_value_reg == '0), "error result nonzero")
    `BSC_ASSERT(a_b5_update, clk, rst_n,
        !$stable(b5_reg) |-> $past(state_reg == S_T_B5), "stored b5 changed out of turn")
    `BSC_ASSERT_ALWAYS(a_busy_after_accept, clk,
        (rst_n && accept) |=> !sample.ready, "block still ready after taking an item")

endmodule

>>> tb/tb.sv
// testbench for baro_sensor_compensation: self-checking stream and register test
`timescale 1ns / 1ps

module tb
    import bsc_pkg::*;
();

    // one compensated result as it leaves the block
    typedef struct packed {
        logic               kind;
        logic [VALUE_W-1:0] value;
        logic               div_error;
    } comp_result_t;

    // compensation constants
    localparam logic [31:0] B6_BIAS    = 32'd4000;
    localparam logic [31:0] X3_OFFSET  = 32'd32768;
    localparam logic [31:0] B7_FACTOR  = 32'd50000;
    localparam logic [31:0] P_SQ_COEF  = 32'd3038;
    localparam logic [31:0] P_LIN_COEF = 32'hFFFF_E343;
    localparam logic [31:0] P_OFFSET   = 32'd3791;
    localparam logic [31:0] WORD_MSB   = 32'h8000_0000;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    bsc_sample_if sample_ch ();
    bsc_result_if result_ch ();

    baro_sensor_compensation DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (sample_ch),
        .result  (result_ch)
    );

    // local copy of the calibration registers and the stored b5
    logic [1:0]  cal_oss     = OSS_RESET;
    logic [15:0] cal_ac1     = 16'd408;
    logic [15:0] cal_ac2     = 16'hFFB8;
    logic [15:0] cal_ac3     = 16'hC7D1;
    logic [15:0] cal_ac4     = 16'd32741;
    logic [31:0] cal_ac5_ac6 = 32'd2146785905;
    logic [31:0] cal_b1_b2   = 32'd405667844;
    logic [31:0] cal_mc_md   = 32'd3724086068;
    logic [31:0] stored_b5   = 32'd0;

    comp_result_t pending_results[$];

    int send_idle_pct    = 0;
    int result_stall_pct = 0;
    int holdoff_request  = 0;
    int holdoff_left     = 0;
    int mismatch_count   = 0;
    int items_sent       = 0;
    int temp_checked     = 0;
    int press_checked    = 0;
    int div_err_seen     = 0;
    int reg_writes       = 0;
    int cal_settings     = 1;

    // arithmetic shift right of a 32-bit word
    function automatic logic [31:0] asr32(input logic [31:0] v, input int n);
        return $signed(v) >>> n;
    endfunction

    // signed division truncating toward zero
    function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? (32'd0 - a) : a;
        mb = b[31] ? (32'd0 - b) : b;
        q = ma / mb;
        return (a[31] ^ b[31]) ? (32'd0 - q) : q;
    endfunction

    // expected result of one reading, updates stored b5 on a good temperature
    function automatic comp_result_t compensate_reading(input logic cmd,
                                                        input logic [RAW_W-1:0] raw);
        comp_result_t r;
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] ut, up, x1, x2, x3, den, b3, b4, b6, b7, sq, p, t;
        int sh;
        r.kind = cmd;
        r.value = '0;
        r.div_error = 1'b0;
        ac1 = {{16{cal_ac1[15]}}, cal_ac1};
        ac2 = {{16{cal_ac2[15]}}, cal_ac2};
        ac3 = {{16{cal_ac3[15]}}, cal_ac3};
        ac4 = {16'd0, cal_ac4};
        ac5 = {16'd0, cal_ac5_ac6[31:16]};
        ac6 = {16'd0, cal_ac5_ac6[15:0]};
        b1 = {{16{cal_b1_b2[31]}}, cal_b1_b2[31:16]};
        b2 = {{16{cal_b1_b2[15]}}, cal_b1_b2[15:0]};
        mc = {{16{cal_mc_md[31]}}, cal_mc_md[31:16]};
        md = {{16{cal_mc_md[15]}}, cal_mc_md[15:0]};
        if (cmd == CMD_TEMP)
        begin
            // temperature, upper raw bits ignored
            ut = {16'd0, raw[15:0]};
            x1 = asr32((ut - ac6) * ac5, 15);
            den = x1 + md;
            if (den == 32'd0)
            begin
                r.div_error = 1'b1;
            end
            else
            begin
                x2 = div_trunc(mc << 11, den);
                stored_b5 = x1 + x2;
                r.value = asr32(stored_b5 + 32'd8, 4);
            end
        end
        else
        begin
            // pressure from the stored b5
            sh = 8 - int'(cal_oss);
            up = {8'd0, raw} >> sh;
            b6 = stored_b5 - B6_BIAS;
            sq = asr32(b6 * b6, 12);
            x1 = asr32(b2 * sq, 11);
            x2 = asr32(ac2 * b6, 11);
            x3 = x1 + x2;
            b3 = asr32(((ac1 * 32'd4 + x3) << cal_oss) + 32'd2, 2);
            x1 = asr32(ac3 * b6, 13);
            x2 = asr32(b1 * sq, 16);
            x3 = asr32(x1 + x2 + 32'd2, 2);
            b4 = (ac4 * (x3 + X3_OFFSET)) >> 15;
            b7 = (up - b3) * (B7_FACTOR >> cal_oss);
            if (b4 == 32'd0)
            begin
                r.div_error = 1'b1;
            end
            else
            begin
                if (b7 < WORD_MSB)
                    p = (b7 << 1) / b4;
                else
                    p = (b7 / b4) << 1;
                t = asr32(p, 8);
                x1 = asr32((t * t) * P_SQ_COEF, 16);
                x2 = asr32(P_LIN_COEF * p, 16);
                r.value = p + asr32(x1 + x2 + P_OFFSET, 4);
            end
        end
        return r;
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

    // result receiver with random stalls and an optional long hold-off
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_request != 0)
            begin
                holdoff_left = holdoff_request;
                holdoff_request = 0;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= result_stall_pct);
            end
        end
    end

    // result checker
    initial
    begin
        comp_result_t want;
        comp_result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                got.kind = result_ch.kind;
                got.value = result_ch.value;
                got.div_error = result_ch.div_error;
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: unexpected item kind=%0b value=%0d div_error=%0b",
                                 got.kind, $signed(got.value), got.div_error);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.kind !== want.kind || got.value !== want.value ||
                        got.div_error !== want.div_error)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: kind/value/div_error expected %0b/%0d/%0b got %0b/%0d/%0b",
                                     want.kind, $signed(want.value), want.div_error,
                                     got.kind, $signed(got.value), got.div_error);
                    end
                    if (want.kind == CMD_TEMP)
                        temp_checked++;
                    else
                        press_checked++;
                    if (want.div_error)
                        div_err_seen++;
                end
            end
        end
    end

    // offer one reading and record its expected result once taken
    task automatic send_reading(input logic cmd, input logic [RAW_W-1:0] raw);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.cmd <= cmd;
        sample_ch.raw_reading <= raw;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        pending_results.push_back(compensate_reading(cmd, raw));
        items_sent++;
        @(negedge clk);
    endtask

    // stop offering and wait until every result is out
    task automatic drain_block();
        sample_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // register write: setup and access cycle, mirrored in the local copy
    task automatic write_reg(input bsc_reg_t idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_OVERSAMPLING: cal_oss = data[1:0];
            REG_AC1:          cal_ac1 = data[15:0];
            REG_AC2:          cal_ac2 = data[15:0];
            REG_AC3:          cal_ac3 = data[15:0];
            REG_AC4:          cal_ac4 = data[15:0];
            REG_AC5_AC6:      cal_ac5_ac6 = data;
            REG_B1_B2:        cal_b1_b2 = data;
            REG_MC_MD:        cal_mc_md = data;
            default:          ;
        endcase
        reg_writes++;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    // drain the block, then write all calibration registers
    task automatic load_calibration(input logic [1:0] oss, input logic [15:0] ac1,
                                    input logic [15:0] ac2, input logic [15:0] ac3,
                                    input logic [15:0] ac4, input logic [31:0] ac56,
                                    input logic [31:0] b1b2, input logic [31:0] mcmd);
        drain_block();
        write_reg(REG_OVERSAMPLING, {30'd0, oss});
        write_reg(REG_AC1, {16'd0, ac1});
        write_reg(REG_AC2, {16'd0, ac2});
        write_reg(REG_AC3, {16'd0, ac3});
        write_reg(REG_AC4, {16'd0, ac4});
        write_reg(REG_AC5_AC6, ac56);
        write_reg(REG_B1_B2, b1b2);
        write_reg(REG_MC_MD, mcmd);
        cal_settings++;
    endtask

    function automatic logic [31:0] pick_setting(input logic [31:0] dflt);
        case ($urandom_range(3))
            0: return dflt;
            1:
            begin
                case ($urandom_range(3))
                    0: return 32'h0000_0000;
                    1: return 32'hFFFF_FFFF;
                    2: return 32'h8000_8000;
                    default: return 32'h7FFF_7FFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [RAW_W-1:0] pick_raw();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            default: return RAW_W'($urandom);
        endcase
    endfunction

    // reset coefficients, pressure with b5 still zero, then the usual sequence
    task automatic test_reset_state();
        send_reading(CMD_PRESS, 24'h5D_2300);
        send_reading(CMD_TEMP, 24'hFF_6CFA);
        send_reading(CMD_PRESS, 24'h5D_2300);
        send_reading(CMD_PRESS, 24'h00_0000);
        send_reading(CMD_PRESS, 24'hFF_FFFF);
    endtask

    // coefficient and field extremes
    task automatic test_field_extremes();
        load_calibration(2'd0, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF,
                         32'hFFFF_FFFF, 32'h8000_7FFF, 32'h7FFF_8000);
        send_reading(CMD_TEMP, 24'h00_0000);
        send_reading(CMD_PRESS, 24'hFF_FFFF);
        send_reading(CMD_TEMP, 24'hFF_FFFF);
        send_reading(CMD_PRESS, 24'h00_0000);
        load_calibration(2'd3, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0001,
                         32'h0000_0001, 32'h7FFF_8000, 32'h8000_7FFF);
        send_reading(CMD_TEMP, 24'hFF_FFFF);
        send_reading(CMD_PRESS, 24'hFF_FFFF);
        send_reading(CMD_TEMP, 24'h00_0000);
        send_reading(CMD_PRESS, 24'h00_0000);
    endtask

    // zero divisors in the temperature and pressure paths
    task automatic test_divide_by_zero();
        load_calibration(OSS_RESET, AC1_RESET, AC2_RESET, AC3_RESET, AC4_RESET,
                         AC56_RESET, B1B2_RESET, MCMD_RESET);
        send_reading(CMD_TEMP, 24'h00_6CFA);
        // ac5 = 32768 makes x1 = ut - ac6 = 100, md = -100 cancels it
        drain_block();
        write_reg(REG_AC5_AC6, {16'd32768, 16'd1000});
        write_reg(REG_MC_MD, {16'd2000, 16'hFF9C});
        send_reading(CMD_TEMP, 24'h00_044C);
        // ac5 = 0 with md = 0
        drain_block();
        write_reg(REG_AC5_AC6, {16'd0, 16'd1000});
        write_reg(REG_MC_MD, {16'd2000, 16'd0});
        send_reading(CMD_TEMP, 24'h12_3456);
        send_reading(CMD_PRESS, 24'h5D_2300);
        // ac4 = 0 zeroes b4
        drain_block();
        write_reg(REG_AC4, 32'd0);
        send_reading(CMD_PRESS, 24'h5D_2300);
    endtask

    // each oversampling setting
    task automatic test_oversampling();
        int oss;
        load_calibration(OSS_RESET, AC1_RESET, AC2_RESET, AC3_RESET, AC4_RESET,
                         AC56_RESET, B1B2_RESET, MCMD_RESET);
        send_reading(CMD_TEMP, 24'h00_6CFA);
        for (oss = 0; oss < 4; oss++)
        begin
            drain_block();
            write_reg(REG_OVERSAMPLING, 32'(oss));
            send_reading(CMD_PRESS, 24'h5D_23A7);
        end
    endtask

    // long output hold-off while readings keep coming
    task automatic test_backpressure();
        int n;
        send_idle_pct = 0;
        result_stall_pct = 0;
        holdoff_request = 300;
        for (n = 0; n < 12; n++)
            send_reading(n[0] ? CMD_PRESS : CMD_TEMP, pick_raw());
        drain_block();
    endtask

    // random calibration and readings, mostly temperature then pressures
    task automatic test_random_phase(input int n_items, input int idle_pct, input int stall);
        int start;
        int burst;
        load_calibration(2'($urandom_range(3)),
                         16'(pick_setting(AC1_RESET)), 16'(pick_setting(AC2_RESET)),
                         16'(pick_setting(AC3_RESET)), 16'(pick_setting(AC4_RESET)),
                         pick_setting(AC56_RESET), pick_setting(B1B2_RESET),
                         pick_setting(MCMD_RESET));
        send_idle_pct = idle_pct;
        result_stall_pct = stall;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            if ($urandom_range(9) < 8)
            begin
                send_reading(CMD_TEMP, pick_raw());
                burst = $urandom_range(1, 3);
                repeat (burst) send_reading(CMD_PRESS, pick_raw());
            end
            else
            begin
                send_reading(1'($urandom_range(1)), pick_raw());
            end
        end
        drain_block();
        send_idle_pct = 0;
        result_stall_pct = 0;
    endtask

    // test sequence
    initial
    begin
        int guard;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sample_ch.valid = 1'b0;
        sample_ch.cmd = CMD_TEMP;
        sample_ch.raw_reading = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_field_extremes();
        test_divide_by_zero();
        test_oversampling();
        test_backpressure();
        test_random_phase(175, 0, 0);
        test_random_phase(175, 75, 0);
        test_random_phase(175, 0, 75);
        test_random_phase(175, 26, 26);

        // let the last results out
        sample_ch.valid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (60) @(negedge clk);
        if (pending_results.size() != 0)
        begin
            $display("mismatch: %0d expected items never arrived", pending_results.size());
            mismatch_count += pending_results.size();
        end

        $display("summary: %0d temperature and %0d pressure items checked, %0d with divide error",
                 temp_checked, press_checked, div_err_seen);
        $display("summary: %0d register writes over %0d calibration sets, %0d mismatches",
                 reg_writes, cal_settings, mismatch_count);
        if (mismatch_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
